// File: hw/rtl/assert_macros.svh
// assertion helpers used by the checker file nscc_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/nscc_pkg.sv
// ----------------------------------------------------------------------------
// nscc_pkg
// Shared types and constants of the NMEA sentence checksum checker.
// ----------------------------------------------------------------------------
`default_nettype none

package nscc_pkg;

	// longest sentence before overflow is reported at MAX_LEN-1 bytes
	localparam int MAX_LEN = 128;

	// opcode of an input word
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// report status codes
	localparam logic [1:0] ST_GOOD     = 2'd0;
	localparam logic [1:0] ST_BAD      = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;
	localparam logic [1:0] ST_TIMEOUT  = 2'd3;

	// characters of interest
	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;

	typedef struct packed {
		logic [1:0] status;
		logic [6:0] sentence_length;
		logic [7:0] computed_sum;
		logic [7:0] received_sum;
	} report_t;

	// report raised by the parser for the result register
	typedef struct packed {
		logic    valid;
		report_t rpt;
	} evt_t;

endpackage

`default_nettype wire

// File: hw/rtl/nscc_if.sv
// ----------------------------------------------------------------------------
// nscc_if
// Valid/ready channels of the checker: received words in, reports out.
// ----------------------------------------------------------------------------
`default_nettype none

interface nscc_rx_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] byte_value;

	modport source (output valid, output opcode, output byte_value, input ready);
	modport sink (input valid, input opcode, input byte_value, output ready);
endinterface

interface nscc_rpt_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [6:0] sentence_length;
	logic [7:0] computed_sum;
	logic [7:0] received_sum;

	modport source (output valid, output status, output sentence_length,
		output computed_sum, output received_sum, input ready);
	modport sink (input valid, input status, input sentence_length,
		input computed_sum, input received_sum, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/nscc_parser.sv
// ----------------------------------------------------------------------------
// nscc_parser
// Sentence state and its update: dollar hunt, running xor, hex checksum,
// length and tick counting, and the report raised on an accepted word.
// ----------------------------------------------------------------------------
`default_nettype none

module nscc_parser (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               accept,
	input  wire               opcode,
	input  wire  [7:0]        byte_value,
	input  wire  [15:0]       timeout_ticks,
	output nscc_pkg::evt_t    evt
);
	import nscc_pkg::*;

	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_BODY = 3'd1;
	localparam logic [2:0] PH_HI   = 3'd2;
	localparam logic [2:0] PH_LO   = 3'd3;
	localparam logic [2:0] PH_TAIL = 3'd4;

	localparam logic [6:0] LEN_LIMIT = 7'(MAX_LEN - 1);

	logic [2:0]  phase_q,    phase_d;
	logic [7:0]  xor_q,      xor_d;
	logic [7:0]  sent_q,     sent_d;
	logic [6:0]  count_q,    count_d;
	logic [15:0] tick_q,     tick_d;

	logic [15:0] tick_inc;
	logic [6:0]  count_inc;
	logic        in_sentence;

	// hex digit value, anything outside 0-9 and A-F reads as zero
	function automatic logic [3:0] hex_value(input logic [7:0] b);
		logic [7:0] off;
		off = 8'h00;
		if (b >= CH_ZERO && b <= CH_NINE) begin
			off = b - CH_ZERO;
		end else if (b >= CH_UPPER_A && b <= CH_UPPER_F) begin
			off = b - CH_UPPER_A + 8'd10;
		end
		return off[3:0];
	endfunction

	assign tick_inc    = tick_q + 16'd1;
	assign count_inc   = count_q + 7'd1;
	assign in_sentence = (phase_q >= PH_BODY) && (phase_q <= PH_TAIL);

	// next state and report for the word on the input
	always_comb begin
		phase_d   = phase_q;
		xor_d     = xor_q;
		sent_d    = sent_q;
		count_d   = count_q;
		tick_d    = tick_q;
		evt.valid = 1'b0;
		evt.rpt   = '{status: ST_GOOD, sentence_length: count_q,
			computed_sum: xor_q, received_sum: sent_q};

		if (opcode == OP_TICK) begin
			tick_d = tick_inc;
			if (tick_inc >= timeout_ticks) begin
				evt.valid          = 1'b1;
				evt.rpt.status     = ST_TIMEOUT;
			end
		end else if (!in_sentence) begin
			if (byte_value == CH_DOLLAR) begin
				phase_d = PH_BODY;
				xor_d   = 8'h00;
				sent_d  = 8'h00;
				count_d = 7'd1;
			end
		end else begin
			count_d = count_inc;
			if (byte_value == CH_NEWLINE) begin
				evt.valid               = 1'b1;
				evt.rpt.sentence_length = count_inc;
				if (phase_q == PH_BODY || sent_q != xor_q) begin
					evt.rpt.status = ST_BAD;
				end
			end else begin
				case (phase_q)
					PH_BODY: begin
						if (byte_value == CH_STAR) begin
							phase_d = PH_HI;
						end else begin
							xor_d = xor_q ^ byte_value;
						end
					end
					PH_HI: begin
						sent_d  = {hex_value(byte_value), 4'h0};
						phase_d = PH_LO;
					end
					PH_LO: begin
						sent_d  = sent_q + {4'h0, hex_value(byte_value)};
						phase_d = PH_TAIL;
					end
					default: begin
					end
				endcase
				if (count_inc >= LEN_LIMIT) begin
					evt.valid = 1'b1;
					evt.rpt   = '{status: ST_OVERFLOW, sentence_length: count_inc,
						computed_sum: xor_d, received_sum: sent_d};
				end
			end
		end

		// any report starts a fresh hunt
		if (evt.valid) begin
			phase_d = PH_HUNT;
			xor_d   = 8'h00;
			sent_d  = 8'h00;
			count_d = 7'd0;
			tick_d  = 16'd0;
		end
	end

	// sentence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			xor_q   <= 8'h00;
			sent_q  <= 8'h00;
			count_q <= 7'd0;
			tick_q  <= 16'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			xor_q   <= xor_d;
			sent_q  <= sent_d;
			count_q <= count_d;
			tick_q  <= tick_d;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/nscc_out_stage.sv
// ----------------------------------------------------------------------------
// nscc_out_stage
// Result register between the parser and the report channel; frees the
// input side whenever the held report is empty or being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module nscc_out_stage (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  accept,
	input  nscc_pkg::evt_t       evt,
	input  wire                  taken_ready,
	output logic                 space,
	output logic                 valid,
	output nscc_pkg::report_t    rpt
);
	import nscc_pkg::*;

	logic    valid_q;
	report_t rpt_q;

	assign space = !valid_q || taken_ready;
	assign valid = valid_q;
	assign rpt   = rpt_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept && evt.valid) begin
			valid_q <= 1'b1;
		end else if (taken_ready) begin
			valid_q <= 1'b0;
		end
	end

	// report payload
	always_ff @(posedge clk) begin
		if (accept && evt.valid) begin
			rpt_q <= evt.rpt;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/nmea_sentence_checksum_checker_core.sv
// ----------------------------------------------------------------------------
// nmea_sentence_checksum_checker_core
// NMEA 0183 sentence checksum checker, one received byte or tick per word.
// ----------------------------------------------------------------------------
// Takes one word per clock while rx.ready is up: a received byte or a tick.
// After a '$' it xors every byte up to '*', decodes the two hex characters
// that follow and raises a report with status (good or bad on newline,
// overflow at the length limit, timeout on ticks), length and both sums.
// rx.ready only drops while a report is held and report.ready is low. A
// report is offered the cycle after its word. timeout_ticks is written via
// cfg_we/cfg_wdata while idle; the user must ensure it, the block does not.
`default_nettype none

module nmea_sentence_checksum_checker_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [15:0] cfg_wdata,
	nscc_rx_if.sink     rx,
	nscc_rpt_if.source  report
);
	import nscc_pkg::*;

	logic [15:0] timeout_q;
	logic        accept;
	logic        space;
	evt_t        evt;
	report_t     rpt;

	assign rx.ready = space;
	assign accept   = rx.valid && space;

	// timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 16'd1000;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	nscc_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.opcode        (rx.opcode),
		.byte_value    (rx.byte_value),
		.timeout_ticks (timeout_q),
		.evt           (evt)
	);

	nscc_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.evt         (evt),
		.taken_ready (report.ready),
		.space       (space),
		.valid       (report.valid),
		.rpt         (rpt)
	);

	// report payload onto the channel
	assign report.status          = rpt.status;
	assign report.sentence_length = rpt.sentence_length;
	assign report.computed_sum    = rpt.computed_sum;
	assign report.received_sum    = rpt.received_sum;

endmodule

`default_nettype wire

// File: hw/rtl/nscc_checker.sv
// ----------------------------------------------------------------------------
// nscc_checker
// Port-level checks of the checker core, bound onto the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nscc_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       rx_valid,
	input wire       rx_ready,
	input wire       rpt_valid,
	input wire       rpt_ready,
	input wire [1:0] status,
	input wire [6:0] sentence_length,
	input wire [7:0] computed_sum,
	input wire [7:0] received_sum
);
	import nscc_pkg::*;

	localparam logic [6:0] LEN_LIMIT = 7'(MAX_LEN - 1);

	// a stalled report stays up
	`ASSERT_NEXT(a_rpt_hold, clk, arst_n, rpt_valid && !rpt_ready, rpt_valid, "report dropped while stalled")

	// an empty result register never stalls the input
	`ASSERT_IMPL(a_rx_free, clk, arst_n, !rpt_valid, rx_ready, "input stalled with no report pending")

	// a new report needs an accepted word the cycle before
	`ASSERT_IMPL(a_rpt_cause, clk, arst_n, $rose(rpt_valid), $past(rx_valid && rx_ready), "report without a word")

	// a good report has matching sums and at least dollar, star and newline
	`ASSERT_IMPL(a_good, clk, arst_n, rpt_valid && status == ST_GOOD, computed_sum == received_sum && sentence_length >= 7'd3, "good report inconsistent")

	// overflow is always reported at the length limit
	`ASSERT_IMPL(a_ovf_len, clk, arst_n, rpt_valid && status == ST_OVERFLOW, sentence_length == LEN_LIMIT, "overflow at wrong length")

endmodule

bind nmea_sentence_checksum_checker_core nscc_checker u_nscc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rx_valid        (rx.valid),
	.rx_ready        (rx.ready),
	.rpt_valid       (report.valid),
	.rpt_ready       (report.ready),
	.status          (report.status),
	.sentence_length (report.sentence_length),
	.computed_sum    (report.computed_sum),
	.received_sum    (report.received_sum)
);

`default_nettype wire
